>>> hdl/vbh_pkg.sv
// Package for the variable-width bin histogram: transaction types, codes and sizes.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package vbh_pkg;

  localparam int MAX_BOUNDS  = 16;
  localparam int BUCKET_CNT  = MAX_BOUNDS + 1;
  localparam int BIDX_W      = 5;   // bucket / boundary index width
  localparam int BND_AW      = 4;   // address width of the boundary table
  localparam int VAL_W       = 64;
  localparam int CNT_W       = 32;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_ORDER = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e              command;
    logic [VAL_W-1:0]  value;
    logic [BIDX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [BIDX_W-1:0] bucket;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  total;
  } out_item_t;

  // Request from the control path to the boundary table.
  typedef struct packed {
    logic              load;
    logic [BIDX_W-1:0] index;
    logic [VAL_W-1:0]  value;
    logic [BIDX_W-1:0] bounds;
  } bnd_req_t;

  // Answer of the boundary table.
  typedef struct packed {
    logic [BIDX_W-1:0] hit;
    status_e           load_status;
  } bnd_rsp_t;

  // Register value clamped to 1..MAX_BOUNDS.
  function automatic logic [BIDX_W-1:0] bounds_in_use(input logic [BIDX_W-1:0] nb);
    logic [BIDX_W-1:0] res;
    if (nb == '0) begin
      res = BIDX_W'(1);
    end else if (nb > BIDX_W'(MAX_BOUNDS)) begin
      res = BIDX_W'(MAX_BOUNDS);
    end else begin
      res = nb;
    end
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
  endfunction

endpackage

>>> hdl/vbh_bounds.sv
// Boundary table of the histogram with parallel bucket search and load checks.
// Depends on vbh_pkg.
`timescale 1ns / 1ps

module vbh_bounds (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vbh_pkg::bnd_req_t req_i,
  output vbh_pkg::bnd_rsp_t rsp_o
);

  logic [vbh_pkg::VAL_W-1:0] bnd_q [vbh_pkg::MAX_BOUNDS];
  logic [vbh_pkg::MAX_BOUNDS-1:0] le_vec;
  logic [vbh_pkg::BND_AW-1:0] prev_idx;
  logic [vbh_pkg::BND_AW-1:0] wr_idx;
  logic [vbh_pkg::BIDX_W-1:0] hit;
  vbh_pkg::status_e load_status;

  always_comb begin
    for (int i = 0; i < vbh_pkg::MAX_BOUNDS; i++) begin
      le_vec[i] = (vbh_pkg::BIDX_W'(i) < req_i.bounds) && (req_i.value <= bnd_q[i]);
    end
  end

  // first boundary at or above the value; overflow bucket if none
  always_comb begin
    hit = req_i.bounds;
    for (int i = vbh_pkg::MAX_BOUNDS - 1; i >= 0; i--) begin
      if (le_vec[i]) begin
        hit = vbh_pkg::BIDX_W'(i);
      end
    end
  end

  assign wr_idx   = req_i.index[vbh_pkg::BND_AW-1:0];
  assign prev_idx = wr_idx - vbh_pkg::BND_AW'(1);

  always_comb begin
    if (req_i.index >= req_i.bounds) begin
      load_status = vbh_pkg::STATUS_RANGE;
    end else if ((req_i.index != '0) && (req_i.value < bnd_q[prev_idx])) begin
      load_status = vbh_pkg::STATUS_ORDER;
    end else begin
      load_status = vbh_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vbh_pkg::MAX_BOUNDS; i++) begin
        bnd_q[i] <= '0;
      end
    end else if (req_i.load && (load_status == vbh_pkg::STATUS_OK)) begin
      bnd_q[wr_idx] <= req_i.value;
    end
  end

  assign rsp_o.hit         = hit;
  assign rsp_o.load_status = load_status;

endmodule

>>> hdl/variable_bin_histogram_top.sv
// Top level of the variable-width bin histogram: handshake, FSM, counter memory.
// Depends on vbh_pkg and vbh_bounds.
//
//   channel | direction | valid       | stall       | payload
//   in      | input     | in_valid_i  | in_stall_o  | in_data_i  (vbh_pkg::in_item_t)
//   out     | output    | out_valid_o | out_stall_i | out_data_o (vbh_pkg::out_item_t)
//   cfg     | input     | APB psel/penable/pwrite, pready always high
//
// A transaction passes accept, lookup with counter read, then update and write back.
// The counter memory read is registered between lookup and update; the FSM waits in ST_HOLD
// for as long as the previous result is still stalled at the output, and the input stalls meanwhile.
// Reset: num_bounds is 1, boundaries, counts and total are zero (counts via valid bits).
// A clear command drops all valid bits at once.
`timescale 1ns / 1ps

module variable_bin_histogram_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  vbh_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output vbh_pkg::out_item_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vbh_pkg::APB_AW-1:0] paddr,
  input  logic [vbh_pkg::APB_DW-1:0] pwdata,
  output logic [vbh_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [vbh_pkg::BIDX_W-1:0] num_bounds_q;
  logic [vbh_pkg::BIDX_W-1:0] n_use;

  vbh_pkg::in_item_t  item_q;
  vbh_pkg::out_item_t out_q, out_d;
  vbh_pkg::out_item_t pend_q, res;
  logic               out_valid_q, out_valid_d;

  vbh_pkg::bnd_req_t bnd_req;
  vbh_pkg::bnd_rsp_t bnd_rsp;

  logic [vbh_pkg::CNT_W-1:0]  cnt_mem [vbh_pkg::BUCKET_CNT];
  logic [vbh_pkg::CNT_W-1:0]  cnt_rd_q;
  logic [vbh_pkg::BUCKET_CNT-1:0] cnt_vld_q;
  logic [vbh_pkg::BIDX_W-1:0] addr_q, addr_d;
  vbh_pkg::status_e           st_q, st_d;
  logic [vbh_pkg::CNT_W-1:0]  total_q;
  logic [vbh_pkg::CNT_W-1:0]  cur_cnt, new_cnt, new_total;

  logic in_acc, slot_free, cfg_wr, cnt_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ?
                  vbh_pkg::APB_DW'(num_bounds_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bounds_q <= vbh_pkg::BIDX_W'(1);
    end else if (cfg_wr) begin
      num_bounds_q <= pwdata[vbh_pkg::BIDX_W-1:0];
    end
  end

  assign n_use = vbh_pkg::bounds_in_use(num_bounds_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
  end

  assign bnd_req.load   = (state_q == ST_LOOK) && (item_q.command == vbh_pkg::CMD_LOAD);
  assign bnd_req.index  = item_q.index;
  assign bnd_req.value  = item_q.value;
  assign bnd_req.bounds = n_use;

  vbh_bounds u_bounds (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (bnd_req),
    .rsp_o  (bnd_rsp)
  );

  // lookup stage: pick the counter address and the status
  always_comb begin
    addr_d = '0;
    st_d   = vbh_pkg::STATUS_OK;
    case (item_q.command)
      vbh_pkg::CMD_SAMPLE: addr_d = bnd_rsp.hit;
      vbh_pkg::CMD_LOAD:   st_d   = bnd_rsp.load_status;
      vbh_pkg::CMD_READ: begin
        if (item_q.index > n_use) begin
          st_d = vbh_pkg::STATUS_RANGE;
        end else begin
          addr_d = item_q.index;
        end
      end
      default: ;
    endcase
  end

  // update stage
  assign cur_cnt   = cnt_vld_q[addr_q] ? cnt_rd_q : '0;
  assign new_cnt   = vbh_pkg::sat_inc(cur_cnt);
  assign new_total = vbh_pkg::sat_inc(total_q);
  assign cnt_wr    = (state_q == ST_UPD) && (item_q.command == vbh_pkg::CMD_SAMPLE);

  always_comb begin
    res.status = st_q;
    res.bucket = '0;
    res.count  = '0;
    res.total  = total_q;
    case (item_q.command)
      vbh_pkg::CMD_SAMPLE: begin
        res.bucket = addr_q;
        res.count  = new_cnt;
        res.total  = new_total;
      end
      vbh_pkg::CMD_READ: begin
        if (st_q == vbh_pkg::STATUS_OK) begin
          res.bucket = addr_q;
          res.count  = cur_cnt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOK) begin
      cnt_rd_q <= cnt_mem[addr_d];
      addr_q   <= addr_d;
      st_q     <= st_d;
    end
    if (cnt_wr) begin
      cnt_mem[addr_q] <= new_cnt;
    end
    if (state_q == ST_UPD) begin
      pend_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      total_q   <= '0;
    end else if ((state_q == ST_LOOK) && (item_q.command == vbh_pkg::CMD_CLEAR)) begin
      cnt_vld_q <= '0;
      total_q   <= '0;
    end else if (cnt_wr) begin
      cnt_vld_q[addr_q] <= 1'b1;
      total_q           <= new_total;
    end
  end

  // FSM and output register
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_UPD;
      ST_UPD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = res;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/vbh_checker.sv
// Port-level checks for the variable-width bin histogram, bound to the top level.
// Depends on vbh_pkg and variable_bin_histogram_top.
`timescale 1ns / 1ps

module vbh_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input vbh_pkg::out_item_t out_data_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one transaction at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // error results carry no bucket and no count
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != vbh_pkg::STATUS_OK) |->
      (out_data_o.bucket == '0) && (out_data_o.count == '0))
    else $error("error result with bucket data");

  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.bucket <= vbh_pkg::BIDX_W'(vbh_pkg::MAX_BOUNDS))
    else $error("bucket beyond overflow bucket");

endmodule

bind variable_bin_histogram_top vbh_checker u_vbh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
